### src/u2u_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ---------------------------------------------------------------------------
package u2u_pkg;

   localparam logic [15:0] REPLACEMENT = 16'hFFFD;
   localparam logic [15:0] HI_SURR     = 16'hD800;
   localparam logic [15:0] LO_SURR     = 16'hDC00;
   localparam logic [20:0] PLANE1      = 21'h10000;
   localparam logic [20:0] BMP_MAX     = 21'h0FFFF;
   localparam logic [9:0]  LOW10_MASK  = 10'h3FF;
   localparam logic [5:0]  CONT_MASK   = 6'h3F;
   localparam logic [4:0]  LEAD2_MASK  = 5'h1F;
   localparam logic [4:0]  LEAD4_CODE  = 5'h1E;

   localparam int unsigned MAX_UNITS = 3;

   typedef logic [15:0] unit_type;

   // Units produced by one decoded byte, oldest in entry 0
   typedef struct packed {
      unit_type [MAX_UNITS-1:0] units;
      logic [1:0]               count;
      logic                     fin;
   } dec_result_type;

endpackage
`default_nettype wire

### src/utf8_to_utf16_transcoder_top.sv
`default_nettype none
// A byte that is accepted passes the input register, then the result
// register, before its first code unit shows on rsp_.
// Throughput: one byte per cycle while the result register can take it; a byte that
// yields u units holds the result register until all u are taken (u is 1 or 2, up to 3 on a final-byte flush).
// A byte that only extends an open sequence yields nothing and never waits.
// Reset (synchronous) empties the input and result registers and clears
// the held-byte count.
// ---------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// Streaming UTF-8 to UTF-16 transcoder: input register, decoder with held
// sequence bytes, and a result register of up to three units.
// ---------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_final_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_code_unit,
   output logic             rsp_end_of_text
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_final_ff;
   logic       accept;
   logic       advance;
   logic       buf_free;
   logic       load;

   u2u_pkg::dec_result_type dec;

   assign advance   = in_valid_ff && (buf_free || dec.count == 2'd0);
   assign load      = advance && dec.count != 2'd0;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_in_byte;
         in_final_ff <= req_final_byte;
      end
   end

   u2u_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_byte    (in_byte_ff),
      .final_byte (in_final_ff),
      .advance    (advance),
      .result     (dec)
   );

   u2u_unit_buf u_unit_buf (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .result          (dec),
      .free            (buf_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_end_of_text (rsp_end_of_text)
   );

   // A final byte always flushes to at least one unit
   a_final_yields_units: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_final_ff) |-> (dec.count != 2'd0))
      else $error("final byte decoded to no units");

   // Only a flush can yield three units
   a_three_only_on_flush: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_final_ff) |-> (dec.count != 2'd3))
      else $error("three units from a non-final byte");

   // A loaded item shows a result in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("loaded units not presented");

   // The end mark goes out only on a shown unit
   a_end_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_end_of_text |-> rsp_valid)
      else $error("end mark without a unit");

endmodule
`default_nettype wire

### src/u2u_decode.sv
`default_nettype none
// ---------------------------------------------------------------------------
// u2u_decode
// Joins the registered byte with the held bytes of an open sequence,
// decodes a complete or flushed run into UTF-16 units, and keeps the
// held bytes of an unfinished sequence.
// ---------------------------------------------------------------------------
module u2u_decode (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [7:0]              in_byte,
   input  wire logic                    final_byte,
   input  wire logic                    advance,
   output u2u_pkg::dec_result_type      result
);

   logic [2:0][7:0] held_ff;
   logic [1:0]      held_count_ff;
   logic [1:0]      held_count_in;

   logic [3:0][7:0] run_bytes;
   logic [2:0]      run_len;
   logic [2:0]      need;
   logic            do_decode;

   function automatic logic [2:0] lead_len(input logic [7:0] c);
      logic [2:0] len;
      len = 3'd0;
      if (c[7] == 1'b0) begin
         len = 3'd1;
      end else if (c[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (c[7:4] == 4'hE) begin
         len = 3'd3;
      end else if (c[7:3] == u2u_pkg::LEAD4_CODE) begin
         len = 3'd4;
      end
      return len;
   endfunction

   function automatic u2u_pkg::dec_result_type decode_run(
      input logic [3:0][7:0] b,
      input logic [2:0]      n,
      input logic            fin
   );
      u2u_pkg::dec_result_type r;
      logic [2:0]  pos;
      logic [2:0]  cnt;
      logic [2:0]  len;
      logic [7:0]  c;
      logic [5:0]  c1;
      logic [5:0]  c2;
      logic [5:0]  c3;
      logic [20:0] cp;
      logic [20:0] cpo;
      r     = '0;
      r.fin = fin;
      pos   = 3'd0;
      cnt   = 3'd0;
      for (int s = 0; s < 4; s++) begin
         if (pos < n) begin
            c   = b[pos[1:0]];
            c1  = b[pos[1:0] + 2'd1][5:0] & u2u_pkg::CONT_MASK;
            c2  = b[pos[1:0] + 2'd2][5:0] & u2u_pkg::CONT_MASK;
            c3  = b[pos[1:0] + 2'd3][5:0] & u2u_pkg::CONT_MASK;
            len = lead_len(c);
            cp  = {5'd0, u2u_pkg::REPLACEMENT};
            if (len != 3'd0 && (pos + len) <= n) begin
               case (len)
                  3'd1:    cp = {13'd0, c};
                  3'd2:    cp = {10'd0, c[4:0] & u2u_pkg::LEAD2_MASK, c1};
                  3'd3:    cp = {5'd0, c[3:0], c1, c2};
                  default: cp = {c[2:0], c1, c2, c3};
               endcase
               pos = pos + len;
            end else begin
               pos = pos + 3'd1;
            end
            if (cp <= u2u_pkg::BMP_MAX) begin
               if (cnt < 3'd3) begin
                  r.units[cnt[1:0]] = cp[15:0];
               end
               if (cnt < 3'd3) cnt = cnt + 3'd1;
            end else begin
               cpo = cp - u2u_pkg::PLANE1;
               if (cnt < 3'd3) begin
                  r.units[cnt[1:0]] = u2u_pkg::HI_SURR + {5'd0, cpo[20:10]};
               end
               if (cnt < 3'd3) cnt = cnt + 3'd1;
               if (cnt < 3'd3) begin
                  r.units[cnt[1:0]] = u2u_pkg::LO_SURR
                                      + {6'd0, cpo[9:0] & u2u_pkg::LOW10_MASK};
               end
               if (cnt < 3'd3) cnt = cnt + 3'd1;
            end
         end
      end
      r.count = cnt[1:0];
      return r;
   endfunction

   // Held bytes first, then the new byte
   always_comb begin
      run_bytes[3] = in_byte;
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < held_count_ff) begin
            run_bytes[i] = held_ff[i];
         end else begin
            run_bytes[i] = in_byte;
         end
      end
   end

   assign run_len   = {1'b0, held_count_ff} + 3'd1;
   assign need      = lead_len(run_bytes[0]);
   assign do_decode = final_byte || need <= 3'd1 || run_len >= need;

   always_comb begin
      if (do_decode) begin
         result = decode_run(run_bytes, run_len, final_byte);
      end else begin
         result       = '0;
         result.fin   = final_byte;
      end
   end

   assign held_count_in = do_decode ? 2'd0 : run_len[1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
      end else if (advance) begin
         held_count_ff <= held_count_in;
      end
   end

   // Held bytes carry no reset: only entries below the count are read
   always_ff @(posedge clock) begin
      if (advance && !do_decode) begin
         held_ff[held_count_ff] <= in_byte;
      end
   end

endmodule
`default_nettype wire

### src/u2u_unit_buf.sv
`default_nettype none
// ---------------------------------------------------------------------------
// u2u_unit_buf
// Result register for up to three code units of one item; shows the
// oldest unit and shifts down on each completed result transaction.
// ---------------------------------------------------------------------------
module u2u_unit_buf (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire u2u_pkg::dec_result_type result,
   output logic                         free,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [15:0]                  rsp_code_unit,
   output logic                         rsp_end_of_text
);

   u2u_pkg::unit_type [u2u_pkg::MAX_UNITS-1:0] units_ff;
   u2u_pkg::unit_type [u2u_pkg::MAX_UNITS-1:0] units_in;
   logic [1:0] remain_ff;
   logic [1:0] remain_in;
   logic       fin_ff;
   logic       fin_in;
   logic       pop;

   assign rsp_valid       = remain_ff != 2'd0;
   assign pop             = rsp_valid && !rsp_stall;
   assign free            = !rsp_valid || (remain_ff == 2'd1 && !rsp_stall);
   assign rsp_code_unit   = units_ff[0];
   assign rsp_end_of_text = fin_ff && remain_ff == 2'd1;

   always_comb begin
      units_in  = units_ff;
      remain_in = remain_ff;
      fin_in    = fin_ff;
      if (load) begin
         units_in  = result.units;
         remain_in = result.count;
         fin_in    = result.fin;
      end else if (pop) begin
         // advance to the next unit of the same item
         units_in[0] = units_ff[1];
         units_in[1] = units_ff[2];
         remain_in   = remain_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 2'd0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      units_ff <= units_in;
      fin_ff   <= fin_in;
   end

endmodule
`default_nettype wire
